@@ hdl/lru_page_replacement_assert.svh @@
// Assertion macros shared by the block's RTL.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define LRUPR_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Checks that a consequent follows an antecedent by a fixed number of cycles.
`define LRUPR_ASSERT_DLY(label, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> ##dly (cons)) else $error(msg);

`endif

@@ hdl/lrupr_pkg.sv @@
package lrupr_pkg;

	// Configuration port geometry.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int CFG_W  = 9;

	// Register index of frames_in_use.
	localparam logic REG_FRAMES_IN_USE = 1'b0;

	localparam logic [CFG_W-1:0] FRAMES_RST = 9'd256;

	// Width of the reported evicted page number.
	localparam int EVICT_PG_W = 20;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} lrupr_st_t;

	// Per-cell control from the sequencer.
	typedef struct packed {
		logic valid;  // cell lies inside the occupied part of the list
		logic tail;   // cell holds the least recent valid page
		logic shift;  // cell loads its front neighbor's page (cell zero: the requested page) this cycle
	} lrupr_cell_ctl_t;

endpackage

@@ hdl/lrupr_cell.sv @@
module lrupr_cell #(
	parameter int PG_W = 20
) (
	input  logic                      clk,
	input  lrupr_pkg::lrupr_cell_ctl_t ctl,
	input  logic [PG_W-1:0]           key,
	input  logic [PG_W-1:0]           prev,
	output logic [PG_W-1:0]           page,
	output logic                      match,
	output logic [PG_W-1:0]           tail_page
);
	import lrupr_pkg::*;

	logic [PG_W-1:0] page_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			page_q <= prev;
		end
	end

	assign page      = page_q;
	assign match     = ctl.valid && (page_q == key);
	assign tail_page = ctl.tail ? page_q : '0;

endmodule

@@ hdl/lru_page_replacement.sv @@
// Least-recently-used page replacement over up to MAX_FRAMES fully associative
// frames. A request carries a 32-bit access address whose upper PAGE_BITS bits
// (the whole address when PAGE_BITS is 32 or more) form the page number. The
// resident pages sit in a row of cells ordered by recency, most recent in cell
// zero. Every request passes through a compare state and a shift state: in the
// compare state, every cell compares its page with the requested page at once
// and the matching cell and the least recent page are picked out; in the shift
// state, the cells in front of the hit (or all cells on a miss) shift one place
// back while the new page enters cell zero. The next request is taken during
// the shift state, before the previous one is through; busy is high only in the
// compare state. The result is registered in the shift state and stays for
// exactly one cycle, marked by done; the receiver cannot stall the block,
// so it must capture the result in that cycle. The page list needs no
// clearing after reset: an occupancy count tells which cells hold pages, and
// the block takes requests from the first cycle after reset. frames_in_use
// (byte address 0) bounds how many frames fill before eviction starts; zero acts
// as one and values above MAX_FRAMES act as MAX_FRAMES. Write it only while the
// block is idle. The hit and miss totals saturate at their maximum value.
module lru_page_replacement #(
	parameter int MAX_FRAMES = 256,
	parameter int PAGE_BITS  = 20
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Request channel.
	input  logic                               start,
	output logic                               busy,
	input  logic [31:0]                        access_address,
	// Result channel.
	output logic                               done,
	output logic                               hit,
	output logic                               evicted,
	output logic [lrupr_pkg::EVICT_PG_W-1:0]   evicted_page,
	output logic [31:0]                        miss_total,
	output logic [31:0]                        hit_total,
	// Configuration port.
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [lrupr_pkg::ADDR_W-1:0]       paddr,
	input  logic [lrupr_pkg::DATA_W-1:0]       pwdata,
	output logic [lrupr_pkg::DATA_W-1:0]       prdata,
	output logic                               pready
);
	import lrupr_pkg::*;

	`include "lru_page_replacement_assert.svh"

	// Page numbers are at most as wide as the address.
	localparam int PG_W  = (PAGE_BITS < 32) ? PAGE_BITS : 32;
	localparam int OCC_W = $clog2(MAX_FRAMES + 1);
	localparam int IDX_W = $clog2(MAX_FRAMES);
	localparam int LIM_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;

	// Sequencer.
	lrupr_st_t state_q, state_nxt;
	logic      accept;
	logic      in_cmp;
	logic      in_upd;

	// Configuration.
	logic [CFG_W-1:0] frames_q;
	logic [LIM_W-1:0] frames_ext;
	logic [LIM_W-1:0] limit;
	logic             cfg_wr;

	// List state.
	logic [PG_W-1:0]  key_q;
	logic [OCC_W-1:0] occ_q;
	logic [OCC_W-1:0] occ_m1;
	logic [IDX_W-1:0] tail_idx;

	// Cell row.
	logic [PG_W-1:0]       cell_pg   [MAX_FRAMES];
	logic [PG_W-1:0]       cell_tail [MAX_FRAMES];
	logic [MAX_FRAMES-1:0] cell_match;

	// Compare stage results.
	logic [IDX_W-1:0] found;
	logic             any_match;
	logic [PG_W-1:0]  victim;
	logic             hit_s1;
	logic             evict_s1;
	logic [IDX_W-1:0] found_s1;
	logic [PG_W-1:0]  victim_s1;
	logic [PG_W+EVICT_PG_W-1:0] victim_ext;

	// Result registers.
	logic                  done_q;
	logic                  hit_q;
	logic                  evicted_q;
	logic [EVICT_PG_W-1:0] evicted_page_q;
	logic [31:0]           miss_cnt_q;
	logic [31:0]           hit_cnt_q;

	// A request is taken whenever the compare cycle is not in progress.
	assign accept = start && !busy;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = ST_CMP;
				end
			end
			ST_CMP: begin
				state_nxt = ST_UPD;
			end
			ST_UPD: begin
				state_nxt = start ? ST_CMP : ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy   = 1'b0;
		in_cmp = 1'b0;
		in_upd = 1'b0;
		case (state_q)
			ST_IDLE: begin
			end
			ST_CMP: begin
				busy   = 1'b1;
				in_cmp = 1'b1;
			end
			ST_UPD: begin
				in_upd = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// The requested page is held for the compare cycle and enters cell zero on
	// the following shift.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= access_address[31 -: PG_W];
		end
	end

	// Configuration port: one register, zero wait states.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RST;
		end else if (cfg_wr && (paddr[2] == REG_FRAMES_IN_USE)) begin
			frames_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_FRAMES_IN_USE) begin
			prdata[CFG_W-1:0] = frames_q;
		end
	end

	// Effective frame limit: zero acts as one, anything above the row length
	// acts as the row length.
	assign frames_ext = LIM_W'(frames_q);

	always_comb begin
		if (frames_ext == '0) begin
			limit = LIM_W'(1);
		end else if (frames_ext > LIM_W'(MAX_FRAMES)) begin
			limit = LIM_W'(MAX_FRAMES);
		end else begin
			limit = frames_ext;
		end
	end

	// The least recent valid page lives in the cell just below the occupancy.
	assign occ_m1   = occ_q - OCC_W'(1);
	assign tail_idx = occ_m1[IDX_W-1:0];

	// Row of cells. Cell zero takes the requested page; every other cell takes
	// its front neighbor's page. On a miss the whole row shifts, since cells at
	// or beyond the occupancy are never looked at; on a hit only the cells up
	// to and including the matching one shift.
	for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
		lrupr_cell_ctl_t ctl;
		logic [PG_W-1:0] prev;

		assign ctl.valid = OCC_W'(i) < occ_q;
		assign ctl.tail  = IDX_W'(i) == tail_idx;
		assign ctl.shift = in_upd && (!hit_s1 || (IDX_W'(i) <= found_s1));

		if (i == 0) begin : g_head
			assign prev = key_q;
		end else begin : g_body
			assign prev = cell_pg[i-1];
		end

		lrupr_cell #(
			.PG_W (PG_W)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.key       (key_q),
			.prev      (prev),
			.page      (cell_pg[i]),
			.match     (cell_match[i]),
			.tail_page (cell_tail[i])
		);
	end

	// Resident pages are unique, so at most one cell matches and the OR of the
	// matching indices is the hit position. The tail page is gathered the same
	// way from the one cell flagged as tail.
	always_comb begin
		found     = '0;
		any_match = 1'b0;
		victim    = '0;
		for (int i = 0; i < MAX_FRAMES; i++) begin
			if (cell_match[i]) begin
				found = found | IDX_W'(i);
			end
			any_match = any_match | cell_match[i];
			victim    = victim | cell_tail[i];
		end
	end

	always_ff @(posedge clk) begin
		if (in_cmp) begin
			hit_s1    <= any_match;
			found_s1  <= found;
			victim_s1 <= victim;
			evict_s1  <= !any_match && (occ_q != '0) && (LIM_W'(occ_q) >= limit);
		end
	end

	// Occupancy grows only on a miss that finds a free frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (in_upd && !hit_s1 && !evict_s1) begin
			occ_q <= occ_q + OCC_W'(1);
		end
	end

	// Running totals, saturating at the all-ones value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_cnt_q <= '0;
			hit_cnt_q  <= '0;
		end else if (in_upd) begin
			if (hit_s1) begin
				if (hit_cnt_q != '1) begin
					hit_cnt_q <= hit_cnt_q + 32'd1;
				end
			end else if (miss_cnt_q != '1) begin
				miss_cnt_q <= miss_cnt_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_upd;
		end
	end

	// Only the low bits of the victim page are reported.
	assign victim_ext = {{EVICT_PG_W{1'b0}}, victim_s1};

	always_ff @(posedge clk) begin
		if (in_upd) begin
			hit_q          <= hit_s1;
			evicted_q      <= evict_s1;
			evicted_page_q <= evict_s1 ? victim_ext[EVICT_PG_W-1:0] : '0;
		end
	end

	assign done         = done_q;
	assign hit          = hit_q;
	assign evicted      = evicted_q;
	assign evicted_page = evicted_page_q;
	assign miss_total   = miss_cnt_q;
	assign hit_total    = hit_cnt_q;

	`LRUPR_ASSERT(a_occ_bound, occ_q <= OCC_W'(MAX_FRAMES), "occupancy beyond frame count")
	`LRUPR_ASSERT(a_hit_no_evict, !(done && hit && evicted), "hit reported with eviction")
	`LRUPR_ASSERT_DLY(a_req_done, accept, 3, done, "request without result")
	`LRUPR_ASSERT(a_single_match, $onehot0(cell_match), "page resident in two cells")

endmodule

@@ sim/lru_page_replacement_tb.sv @@
`timescale 1ns / 100ps

module lru_page_replacement_tb;
	import lrupr_pkg::*;

	localparam int MAX_FRAMES = 256;
	localparam int PAGE_BITS = 20;

	// Cycles of quiet after the last result before a register write. Every
	// request yields a result, so this is only a margin.
	localparam int SETTLE_CYCLES = 4;
	// Cycles without any request, result or register write before the run
	// is declared hung.
	localparam int STALL_LIMIT = 1000;

	localparam logic [ADDR_W-1:0] FRAMES_ADDR = {REG_FRAMES_IN_USE, 2'b00};

	typedef enum logic {
		KIND_ACCESS,
		KIND_FRAMES_WRITE
	} stim_kind_t;

	// One pending entry of the stimulus: either an access request or a write
	// of frames_in_use. gap_pct is the chance, per cycle, that the driver holds
	// the request back.
	typedef struct {
		stim_kind_t  kind;
		logic [31:0] addr;
		logic [8:0]  frames;
		int unsigned gap_pct;
	} pending_t;

	// What one access is expected to report.
	typedef struct packed {
		logic                  hit;
		logic                  evicted;
		logic [EVICT_PG_W-1:0] evicted_page;
		logic [31:0]           miss_total;
		logic [31:0]           hit_total;
	} page_outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              start = 1'b0;
	logic              busy;
	logic [31:0]       access_address = '0;
	logic              done;
	logic              hit;
	logic              evicted;
	logic [EVICT_PG_W-1:0] evicted_page;
	logic [31:0]       miss_total;
	logic [31:0]       hit_total;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	pending_t      pending_q[$];
	page_outcome_t outcome_q[$];

	// The predictor's own copy of the block's state: the recency-ordered page
	// list (most recent in slot zero), its length, both totals and the
	// frame register.
	logic [PAGE_BITS-1:0] page_list [MAX_FRAMES];
	int unsigned          list_len = 0;
	logic [31:0]          pred_misses = '0;
	logic [31:0]          pred_hits = '0;
	logic [8:0]           frames_cfg = FRAMES_RST;

	int unsigned mismatches = 0;
	int unsigned idle_cycles = 0;
	int unsigned quiet_cycles = 0;

	always #1 clk = ~clk;

	lru_page_replacement #(
		.MAX_FRAMES(MAX_FRAMES),
		.PAGE_BITS(PAGE_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.access_address(access_address),
		.done(done),
		.hit(hit),
		.evicted(evicted),
		.evicted_page(evicted_page),
		.miss_total(miss_total),
		.hit_total(hit_total),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// A frame count of zero behaves as one frame, and counts past the list
	// size behave as the full list.
	function automatic int unsigned frame_limit(input logic [8:0] frames);
		if (frames == 0) begin
			return 1;
		end else if (frames > MAX_FRAMES) begin
			return MAX_FRAMES;
		end
		return frames;
	endfunction

	// Moves slots 0..n-1 one place toward the tail and puts page in front.
	function automatic void push_to_front(input logic [PAGE_BITS-1:0] page,
			input int unsigned n);
		for (int i = n; i > 0; i--) begin
			page_list[i] = page_list[i-1];
		end
		page_list[0] = page;
	endfunction

	// Applies one access to the predicted page list and returns what the
	// block should report for it.
	function automatic page_outcome_t replace_page(input logic [31:0] addr);
		page_outcome_t        res;
		logic [PAGE_BITS-1:0] page;
		int unsigned          slot;
		int unsigned          limit;
		page = addr[31:32-PAGE_BITS];
		limit = frame_limit(frames_cfg);
		res = '0;
		slot = list_len;
		for (int i = 0; i < list_len; i++) begin
			if (slot == list_len && page_list[i] == page) begin
				slot = i;
			end
		end
		if (slot < list_len) begin
			res.hit = 1'b1;
			if (pred_hits != '1) begin
				pred_hits++;
			end
			push_to_front(page, slot);
		end else begin
			if (pred_misses != '1) begin
				pred_misses++;
			end
			// The list keeps its length once it has reached the limit, even
			// when the limit was lowered below it: the tail page makes room.
			if (list_len >= limit) begin
				res.evicted = 1'b1;
				res.evicted_page = page_list[list_len-1];
				push_to_front(page, list_len - 1);
			end else begin
				push_to_front(page, list_len);
				list_len++;
			end
		end
		res.miss_total = pred_misses;
		res.hit_total = pred_hits;
		return res;
	endfunction

	task automatic add_access(input logic [31:0] addr, input int unsigned gap);
		pending_t e;
		e.kind = KIND_ACCESS;
		e.addr = addr;
		e.frames = '0;
		e.gap_pct = gap;
		pending_q.push_back(e);
	endtask

	task automatic set_frames(input logic [8:0] frames);
		pending_t e;
		e.kind = KIND_FRAMES_WRITE;
		e.addr = '0;
		e.frames = frames;
		e.gap_pct = 0;
		pending_q.push_back(e);
	endtask

	task automatic flag_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
		mismatches++;
	endtask

	// Driver. A request is taken at an edge where start is high and busy is
	// low; the predictor runs at that same edge. A frames_in_use write waits
	// until every expected result has come back and the block has had
	// SETTLE_CYCLES quiet cycles, then goes out as a setup phase and an access phase.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				outcome_q.push_back(replace_page(access_address));
			end
			if (psel && penable) begin
				if (pready) begin
					frames_cfg = pending_q[0].frames;
					pending_q.delete(0);
					psel <= 1'b0;
					penable <= 1'b0;
					pwrite <= 1'b0;
				end
			end else if (psel) begin
				penable <= 1'b1;
			end else if (start && busy) begin
				// The block has not taken the request yet; keep it on the bus.
			end else if (pending_q.size() == 0) begin
				start <= 1'b0;
			end else if (pending_q[0].kind == KIND_FRAMES_WRITE) begin
				start <= 1'b0;
				if (outcome_q.size() != 0) begin
					quiet_cycles = 0;
				end else if (quiet_cycles < SETTLE_CYCLES) begin
					quiet_cycles++;
				end else begin
					quiet_cycles = 0;
					psel <= 1'b1;
					pwrite <= 1'b1;
					paddr <= FRAMES_ADDR;
					pwdata <= {{(DATA_W-9){1'b0}}, pending_q[0].frames};
				end
			end else if ($urandom_range(99) < pending_q[0].gap_pct) begin
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				access_address <= pending_q[0].addr;
				pending_q.delete(0);
			end
		end
	end

	// Monitor. A result is valid for exactly the one cycle in which done is
	// high and is checked against the oldest expectation at the edge that
	// ends that cycle.
	always @(posedge clk) begin
		page_outcome_t want;
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				$display("%0t: unexpected result, got hit=%0d evicted=%0d page=0x%0h misses=%0d hits=%0d",
					$time, hit, evicted, evicted_page, miss_total, hit_total);
				mismatches++;
			end else begin
				want = outcome_q.pop_front();
				if (hit !== want.hit) begin
					flag_field("hit", want.hit, hit);
				end
				if (evicted !== want.evicted) begin
					flag_field("evicted", want.evicted, evicted);
				end
				if (evicted_page !== want.evicted_page) begin
					flag_field("evicted_page", want.evicted_page, evicted_page);
				end
				if (miss_total !== want.miss_total) begin
					flag_field("miss_total", want.miss_total, miss_total);
				end
				if (hit_total !== want.hit_total) begin
					flag_field("hit_total", want.hit_total, hit_total);
				end
			end
		end
	end

	// Watchdog: any request, result or register write counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (psel && penable && pwrite && pready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
		$display("lru_page_replacement_tb: done, errors");
		$finish;
	end

	initial begin : stimulus
		logic [PAGE_BITS-1:0] pool_base;
		logic [PAGE_BITS-1:0] last_page;
		logic [PAGE_BITS-1:0] pg;
		logic [11:0]          offset;
		logic [8:0]           frames;
		int unsigned          limit;
		int unsigned          pool_size;
		int unsigned          hot_size;
		int unsigned          gap;
		int unsigned          pick;

		// Directed part, at the reset frame count of 256: the extreme
		// addresses, hits that move a page to the front from the middle of
		// the list, and misses that only grow the list.
		add_access(32'h0000_0000, 0);
		add_access(32'hFFFF_FFFF, 0);
		add_access(32'h0000_0FFF, 0);
		add_access(32'hFFFF_F000, 0);
		add_access(32'hAAAA_A555, 0);
		add_access(32'h5555_5AAA, 0);
		add_access(32'h1234_5678, 0);
		add_access(32'hAAAA_A000, 0);
		// A frame count of zero acts as one, and it now lies below the number
		// of pages already held: misses evict the tail, the list keeps its
		// length and older pages still hit.
		set_frames(9'd0);
		add_access(32'h0000_1000, 0);
		add_access(32'h0000_1ABC, 0);
		add_access(32'h1234_5000, 0);
		add_access(32'h0000_0000, 0);
		set_frames(9'd1);
		add_access(32'h8000_0000, 0);
		add_access(32'h7FFF_FFFF, 0);
		// Counts past the list size act as the full list.
		set_frames(9'd511);
		add_access(32'hDEAD_BEEF, 0);
		add_access(32'h0000_0123, 0);
		set_frames(9'd257);
		add_access(32'hFFFF_FFFF, 0);
		add_access(32'h0000_0000, 0);
		set_frames(9'd2);
		add_access(32'h0000_1000, 0);
		add_access(32'h0000_2000, 0);
		add_access(32'h0000_3000, 0);
		add_access(32'h0000_1000, 0);

		// Random part. Each phase sets a frame count, then draws pages mostly
		// from a pool a little larger than that count, with a hot subset, so
		// hits, misses and evictions all happen; some requests repeat the
		// last page right away and a few are fully random addresses.
		pool_base = PAGE_BITS'($urandom);
		last_page = pool_base;
		for (int phase = 0; phase < 13; phase++) begin
			case (phase)
				0: frames = 9'd256;
				1: frames = 9'd1;
				2: frames = 9'd4;
				3: frames = 9'd0;
				4: frames = 9'd16;
				5: frames = 9'd511;
				6: frames = 9'd2;
				7: frames = 9'd300;
				8: frames = 9'd64;
				9: frames = 9'd3;
				10: frames = 9'($urandom_range(256, 1));
				11: frames = 9'd8;
				default: frames = 9'd257;
			endcase
			// The sender idles in most cycles, in some cycles, or never.
			case (phase % 4)
				1: gap = 87;
				3: gap = 28;
				default: gap = 0;
			endcase
			set_frames(frames);
			limit = frame_limit(frames);
			pool_size = limit + $urandom_range(limit / 2 + 2);
			hot_size = limit / 2 + 1;
			for (int n = 0; n < 150; n++) begin
				pick = $urandom_range(99);
				offset = 12'($urandom);
				if (pick < 10) begin
					add_access($urandom, gap);
					continue;
				end else if (pick < 25) begin
					pg = last_page;
				end else if (pick < 60) begin
					pg = pool_base + PAGE_BITS'($urandom_range(hot_size - 1));
				end else begin
					pg = pool_base + PAGE_BITS'($urandom_range(pool_size - 1));
				end
				last_page = pg;
				add_access({pg, offset}, gap);
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || start || psel || outcome_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (8) @(posedge clk);

		if (outcome_q.size() != 0) begin
			$display("%0t: %0d results never came, oldest expected misses=%0d hits=%0d",
				$time, outcome_q.size(), outcome_q[0].miss_total, outcome_q[0].hit_total);
		end
		if (mismatches == 0 && outcome_q.size() == 0) begin
			$display("lru_page_replacement_tb: done, clean");
		end else begin
			$display("lru_page_replacement_tb: done, errors");
		end
		$finish;
	end

endmodule

@@ lru_page_replacement.f @@
+incdir+hdl
hdl/lrupr_pkg.sv
hdl/lrupr_cell.sv
hdl/lru_page_replacement.sv
sim/lru_page_replacement_tb.sv
